@@ rtl/core/pxn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxn_pkg
// shared types and codes of the paxos node step block
// ----------------------------------------------------------------------------
package pxn_pkg;

  localparam logic [2:0] OP_PREPARE    = 3'd0;
  localparam logic [2:0] OP_PROMISE    = 3'd1;
  localparam logic [2:0] OP_ACCEPT     = 3'd2;
  localparam logic [2:0] OP_RESPONSE   = 3'd3;
  localparam logic [2:0] OP_CONTRIBUTE = 3'd4;

  localparam logic [2:0] KIND_PREPARE  = 3'd0;
  localparam logic [2:0] KIND_PROMISE  = 3'd1;
  localparam logic [2:0] KIND_ACCEPT   = 3'd2;
  localparam logic [2:0] KIND_RESPONSE = 3'd3;
  localparam logic [2:0] KIND_SUCCESS  = 3'd4;
  localparam logic [2:0] KIND_NOT_MET  = 3'd5;

  localparam logic REG_PEER_COUNT = 1'b0;
  localparam logic REG_OWN_NODE   = 1'b1;

  typedef enum logic [1:0] {
    ROLE_PREPARE = 2'd0,
    ROLE_PROMISE = 2'd1,
    ROLE_ACCEPT  = 2'd2
  } role_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FIN,
    ST_WAIT
  } st_e;

  typedef struct packed {
    logic [4:0] peer_count;
    logic [7:0] own_node_id;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  peer;
    logic [7:0]  node;
    logic [63:0] id;
    logic        accept;
    logic [63:0] value;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/paxos_node_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paxos_node_step
// single-decree paxos node: one message or contribute request per beat,
// at most one outgoing message or verdict per beat, apb register port
// ----------------------------------------------------------------------------
// sequence: the output is registered; a stored response passes SCAN, TAIL and
//   FIN before its verdict; one into an empty store goes straight to FIN
// throughput: one beat per cycle in idle, none during the one-read-per-cycle
//   scan; an emit while the output beat is held stalls further input
// reset: asynchronous, clears role, id, counters and output valid; the value
//   memory is not cleared, entries are only read after being written
module paxos_node_step #(
  parameter int MAX_PEERS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [3:0]  peer_i,
  input  wire logic [63:0] proposal_id_i,
  input  wire logic        vote_accepted_i,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [2:0]  out_kind_o,
  output logic      [3:0]  out_peer_o,
  output logic      [7:0]  out_node_o,
  output logic      [63:0] out_id_o,
  output logic             out_accept_o,
  output logic      [63:0] out_value_o
);

  import pxn_pkg::*;

  localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CW = $clog2(MAX_PEERS + 1);

  logic [4:0]    pc_q;
  logic [7:0]    own_q;
  cfg_t          cfg;
  res_t          res;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [63:0]   st_wdata;
  logic          st_re;
  logic [AW-1:0] st_raddr;
  logic [63:0]   st_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= 5'd1;
      own_q <= 8'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_PEER_COUNT: pc_q  <= pwdata[4:0];
        REG_OWN_NODE:   own_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PEER_COUNT: prdata = {27'd0, pc_q};
      REG_OWN_NODE:   prdata = {24'd0, own_q};
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  assign cfg.peer_count  = pc_q;
  assign cfg.own_node_id = own_q;

  pxn_core #(
    .MAX_PEERS(MAX_PEERS),
    .AW       (AW),
    .CW       (CW)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .peer_i         (peer_i),
    .proposal_id_i  (proposal_id_i),
    .vote_accepted_i(vote_accepted_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_o          (res),
    .st_we_o        (st_we),
    .st_waddr_o     (st_waddr),
    .st_wdata_o     (st_wdata),
    .st_re_o        (st_re),
    .st_raddr_o     (st_raddr),
    .st_rdata_i     (st_rdata)
  );

  pxn_store #(
    .DEPTH(MAX_PEERS),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  assign out_kind_o   = res.kind;
  assign out_peer_o   = res.peer;
  assign out_node_o   = res.node;
  assign out_id_o     = res.id;
  assign out_accept_o = res.accept;
  assign out_value_o  = res.value;

endmodule
`default_nettype wire

@@ rtl/core/pxn_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxn_store
// response value memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pxn_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [63:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [63:0]   rdata_o
);

  logic [63:0] mem_q [DEPTH];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/core/pxn_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxn_core
// role state, vote counters and the sequencer that scans the value store
// ----------------------------------------------------------------------------
module pxn_core #(
  parameter int MAX_PEERS = 16,
  parameter int AW        = 4,
  parameter int CW        = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pxn_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        op_i,
  input  wire logic [3:0]        peer_i,
  input  wire logic [63:0]       proposal_id_i,
  input  wire logic              vote_accepted_i,
  input  wire logic [63:0]       value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pxn_pkg::res_t          out_o,
  output logic                   st_we_o,
  output logic      [AW-1:0]     st_waddr_o,
  output logic      [63:0]       st_wdata_o,
  output logic                   st_re_o,
  output logic      [AW-1:0]     st_raddr_o,
  input  wire logic [63:0]       st_rdata_i
);

  import pxn_pkg::*;

  localparam int CMPW = (CW > 6) ? CW : 6;

  st_e         state_q, state_d;
  role_e       role_q, role_d;
  logic [63:0] pid_q, pid_d;
  logic [63:0] prop_q, prop_d;
  logic [CW-1:0] ptot_q, ptot_d;
  logic [CW-1:0] pyes_q, pyes_d;
  logic [CW-1:0] rtot_q, rtot_d;
  logic [CW-1:0] ryes_q, ryes_d;
  logic [CW-1:0] best_q, best_d;
  logic        out_vld_q, out_vld_d;

  logic [CW-1:0] hits_q, hits_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] last_q, last_d;
  logic [63:0]   val_q, val_d;
  logic          cmp_vld_q, cmp_vld_d;
  res_t          res_q, res_d;
  res_t          out_q, out_d;

  logic [CMPW-1:0] maj;
  logic [CMPW-1:0] pc_w;
  logic [CW-1:0]   ptot_n;
  logic [CW-1:0]   pyes_n;
  logic [CW-1:0]   best_new;
  logic [CW-1:0]   best_use;
  logic            slot_free;
  logic            emit;
  res_t            emit_res;
  logic            do_bcast;
  logic            do_verdict;

  assign maj  = CMPW'((6'(cfg_i.peer_count) + 6'd1) >> 1);
  assign pc_w = CMPW'(cfg_i.peer_count);
  assign slot_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    role_d     = role_q;
    pid_d      = pid_q;
    prop_d     = prop_q;
    ptot_d     = ptot_q;
    pyes_d     = pyes_q;
    rtot_d     = rtot_q;
    ryes_d     = ryes_q;
    best_d     = best_q;
    hits_d     = hits_q;
    idx_d      = idx_q;
    last_d     = last_q;
    val_d      = val_q;
    cmp_vld_d  = 1'b0;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    in_ready_o = 1'b0;
    st_we_o    = 1'b0;
    st_waddr_o = rtot_q[AW-1:0];
    st_wdata_o = value_i;
    st_re_o    = 1'b0;
    st_raddr_o = idx_q;
    emit       = 1'b0;
    emit_res   = '0;
    do_bcast   = 1'b0;
    do_verdict = 1'b0;

    if (ptot_q < CW'(MAX_PEERS)) begin
      ptot_n = ptot_q + CW'(1);
      pyes_n = pyes_q + CW'(vote_accepted_i);
    end else begin
      ptot_n = ptot_q;
      pyes_n = pyes_q;
    end

    if (cmp_vld_q && (st_rdata_i == val_q)) begin
      hits_d = hits_q + CW'(1);
    end
    best_new = (hits_q > best_q) ? hits_q : best_q;
    best_use = (state_q == ST_FIN) ? best_new : best_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_i)
            OP_PREPARE: begin
              emit            = 1'b1;
              emit_res.kind   = KIND_PROMISE;
              emit_res.peer   = peer_i;
              emit_res.node   = cfg_i.own_node_id;
              emit_res.id     = pid_q;
              if (proposal_id_i > pid_q) begin
                role_d          = ROLE_ACCEPT;
                pid_d           = proposal_id_i;
                emit_res.id     = proposal_id_i;
                emit_res.accept = 1'b1;
              end
            end
            OP_PROMISE: begin
              ptot_d = ptot_n;
              pyes_d = pyes_n;
              if ((CMPW'(pyes_n) >= maj) && (role_q == ROLE_PROMISE)) begin
                role_d         = ROLE_ACCEPT;
                emit           = 1'b1;
                emit_res.kind  = KIND_ACCEPT;
                emit_res.node  = cfg_i.own_node_id;
                emit_res.id    = pid_q;
                emit_res.value = prop_q;
              end else if ((CMPW'(pyes_n) < maj) && (CMPW'(ptot_n) == pc_w)) begin
                do_bcast = 1'b1;
              end
            end
            OP_ACCEPT: begin
              emit           = 1'b1;
              emit_res.kind  = KIND_RESPONSE;
              emit_res.peer  = peer_i;
              emit_res.node  = cfg_i.own_node_id;
              emit_res.id    = pid_q;
              emit_res.value = value_i;
              if ((proposal_id_i >= pid_q) && (role_q == ROLE_ACCEPT)) begin
                pid_d           = proposal_id_i;
                role_d          = ROLE_PREPARE;
                emit_res.id     = proposal_id_i;
                emit_res.accept = 1'b1;
              end
            end
            OP_RESPONSE: begin
              if (rtot_q < CW'(MAX_PEERS)) begin
                st_we_o = 1'b1;
                val_d   = value_i;
                rtot_d  = rtot_q + CW'(1);
                ryes_d  = ryes_q + CW'(vote_accepted_i);
                hits_d  = CW'(1);
                idx_d   = '0;
                last_d  = AW'(rtot_q - CW'(1));
                state_d = (rtot_q == '0) ? ST_FIN : ST_SCAN;
              end else begin
                do_verdict = 1'b1;
              end
            end
            OP_CONTRIBUTE: begin
              do_bcast = 1'b1;
              prop_d   = value_i;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        st_re_o   = 1'b1;
        cmp_vld_d = 1'b1;
        idx_d     = idx_q + AW'(1);
        if (idx_q == last_q) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        best_d     = best_new;
        do_verdict = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_WAIT: begin
        if (slot_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_verdict) begin
      if ((CMPW'(ryes_q) >= maj) && (CMPW'(best_use) >= maj) && (role_q == ROLE_ACCEPT)) begin
        role_d        = ROLE_PREPARE;
        emit          = 1'b1;
        emit_res.kind = KIND_SUCCESS;
      end else if ((CMPW'(ryes_q) < maj) && (CMPW'(rtot_q) == pc_w)) begin
        emit          = 1'b1;
        emit_res.kind = KIND_NOT_MET;
      end
    end

    if (do_bcast) begin
      pid_d         = pid_q + 64'd1;
      role_d        = ROLE_PROMISE;
      ptot_d        = CW'(1);
      pyes_d        = '0;
      rtot_d        = '0;
      ryes_d        = '0;
      best_d        = '0;
      emit          = 1'b1;
      emit_res      = '0;
      emit_res.kind = KIND_PREPARE;
      emit_res.node = cfg_i.own_node_id;
      emit_res.id   = pid_q + 64'd1;
    end

    if (emit) begin
      if (slot_free) begin
        out_d     = emit_res;
        out_vld_d = 1'b1;
      end else begin
        res_d   = emit_res;
        state_d = ST_WAIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      role_q    <= ROLE_PREPARE;
      pid_q     <= '0;
      prop_q    <= '0;
      ptot_q    <= '0;
      pyes_q    <= '0;
      rtot_q    <= '0;
      ryes_q    <= '0;
      best_q    <= '0;
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      role_q    <= role_d;
      pid_q     <= pid_d;
      prop_q    <= prop_d;
      ptot_q    <= ptot_d;
      pyes_q    <= pyes_d;
      rtot_q    <= rtot_d;
      ryes_q    <= ryes_d;
      best_q    <= best_d;
      out_vld_q <= out_vld_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hits_q <= hits_d;
    idx_q  <= idx_d;
    last_q <= last_d;
    val_q  <= val_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire
